[hw/rtl/dupv_pkg.sv]
// Shared types, constants and character classifiers for the data URI payload validator
`timescale 1ns / 1ps
`default_nettype none

package dupv_pkg;

    localparam int CNT_W  = 28;
    localparam int SIZE_W = 27;

    localparam logic [CNT_W-1:0] MAX_TEXT_BYTES = CNT_W'(128 * 1024 * 1024);
    localparam logic [CNT_W-1:0] MAX_OUT_BYTES  = CNT_W'(64 * 1024 * 1024);

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic [5:0] LOW2_MASK = 6'h03;
    localparam logic [5:0] LOW4_MASK = 6'h0F;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_CHAR   = 3'd1,
        ST_BAD_ESCAPE = 3'd2,
        ST_BAD_SYMBOL = 3'd3,
        ST_PAD        = 3'd4,
        ST_LENGTH     = 3'd5,
        ST_NONCANON   = 3'd6,
        ST_LIMIT      = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_phase_t;

    // Payload state captured when a payload closes
    typedef struct packed {
        logic             mode;
        status_t          err;
        logic [CNT_W-1:0] byte_count;
        logic [CNT_W-1:0] symbol_count;
        logic [1:0]       pad_count;
        logic [5:0]       final_sym;
    } snap_t;

    function automatic logic uri_allowed(input logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A))
        begin
            ok = 1'b1;
        end
        else
        begin
            // ; / ? : @ & = + $ , - _ . ! ~ * ' ( )
            unique case (c)
                8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24,
                8'h2C, 8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28,
                8'h29:   ok = 1'b1;
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    // Bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 5'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = 5'(c - 8'h61 + 8'd10);
        end
        return v;
    endfunction

    // Bit 6 set marks a symbol outside the alphabet
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            v = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            v = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            v = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2B)
        begin
            v = 7'd62;
        end
        else if (c == 8'h2F)
        begin
            v = 7'd63;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/data_uri_payload_validator_top.sv]
// Top level of the data URI payload validator
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-----------------------------------------
//  cfg      | cfg_valid/cfg_ready | base64_mode
//  in       | in_valid/in_stall   | payload_byte, byte_present, last_item
//  out      | out_valid/out_stall | status, decoded_size
//
// One transaction per cycle on the input while in_stall is low; each byte is
// fully scanned in its cycle. A closing transaction is registered into the
// close snapshot register, then evaluated into the result register.
// Input stalls only when both the snapshot and result registers are full and the
// output is stalled. Reset clears all payload state and sets base64_mode to 0.
`timescale 1ns / 1ps
`default_nettype none

module data_uri_payload_validator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        base64_mode,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  payload_byte,
    input  wire logic                        byte_present,
    input  wire logic                        last_item,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [2:0]                       status,
    output logic [dupv_pkg::SIZE_W-1:0]      decoded_size
);
    import dupv_pkg::*;

    logic    mode_reg;
    logic    snap_vld;
    snap_t   snap;
    logic    snap_take;
    status_t status_w;

    assign cfg_ready = 1'b1;
    assign status    = status_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= base64_mode;
        end
    end

    dupv_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .byte_present (byte_present),
        .last_item    (last_item),
        .snap_vld     (snap_vld),
        .snap         (snap),
        .snap_take    (snap_take)
    );

    dupv_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_vld     (snap_vld),
        .snap         (snap),
        .snap_take    (snap_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status_w),
        .decoded_size (decoded_size)
    );

endmodule

`default_nettype wire

[hw/rtl/dupv_scan.sv]
// Per-byte scanner: escape decoding, base64 symbol checks, counters and close snapshot
`timescale 1ns / 1ps
`default_nettype none

module dupv_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           mode,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [7:0]     payload_byte,
    input  wire logic           byte_present,
    input  wire logic           last_item,
    output logic                snap_vld,
    output dupv_pkg::snap_t     snap,
    input  wire logic           snap_take
);
    import dupv_pkg::*;

    esc_phase_t        esc_reg, esc_next;
    logic [3:0]        nib_reg, nib_next;
    status_t           err_reg, err_next;
    logic [CNT_W-1:0]  bc_reg, bc_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;
    logic [1:0]        pc_reg, pc_next;
    logic              ps_reg, ps_next;
    logic [5:0]        fsv_reg, fsv_next;
    logic              snap_vld_reg;
    snap_t             snap_reg, snap_next;

    logic              accept;
    logic              close;
    logic              dec_go;
    logic [7:0]        dec_byte;
    logic [4:0]        hexv;
    logic [6:0]        b64v;
    logic [CNT_W-1:0]  bc_inc;
    logic [1:0]        pc_inc;

    assign in_stall = snap_vld_reg & ~snap_take;
    assign accept   = in_valid & ~in_stall;
    assign close    = accept & last_item;
    assign snap_vld = snap_vld_reg;
    assign snap     = snap_reg;
    assign hexv     = hex_value(payload_byte);
    assign bc_inc   = bc_reg + CNT_W'(1);
    assign pc_inc   = pc_reg + 2'd1;

    always_comb
    begin
        esc_next  = esc_reg;
        nib_next  = nib_reg;
        err_next  = err_reg;
        bc_next   = bc_reg;
        sc_next   = sc_reg;
        pc_next   = pc_reg;
        ps_next   = ps_reg;
        fsv_next  = fsv_reg;
        dec_go    = 1'b0;
        dec_byte  = payload_byte;
        b64v      = 7'h40;
        snap_next = snap_reg;

        if (accept && byte_present && err_reg == ST_OK)
        begin
            unique case (esc_reg)
                ESC_IDLE:
                begin
                    if (payload_byte == CH_PERCENT)
                    begin
                        esc_next = ESC_HIGH;
                    end
                    else if (!uri_allowed(payload_byte))
                    begin
                        err_next = ST_BAD_CHAR;
                    end
                    else
                    begin
                        dec_go = 1'b1;
                    end
                end
                ESC_HIGH:
                begin
                    if (hexv[4])
                    begin
                        err_next = ST_BAD_ESCAPE;
                    end
                    else
                    begin
                        nib_next = hexv[3:0];
                        esc_next = ESC_LOW;
                    end
                end
                ESC_LOW:
                begin
                    if (hexv[4])
                    begin
                        err_next = ST_BAD_ESCAPE;
                    end
                    else
                    begin
                        esc_next = ESC_IDLE;
                        dec_go   = 1'b1;
                        dec_byte = {nib_reg, hexv[3:0]};
                    end
                end
                default:
                begin
                    esc_next = ESC_IDLE;
                end
            endcase
        end

        b64v = b64_value(dec_byte);
        if (dec_go)
        begin
            bc_next = bc_inc;
            if (!mode)
            begin
                if (bc_inc > MAX_OUT_BYTES)
                begin
                    err_next = ST_LIMIT;
                end
            end
            else if (bc_inc > MAX_TEXT_BYTES)
            begin
                err_next = ST_LIMIT;
            end
            else if (dec_byte != CH_TAB && dec_byte != CH_LF &&
                     dec_byte != CH_CR && dec_byte != CH_SPACE)
            begin
                sc_next = sc_reg + CNT_W'(1);
                if (dec_byte == CH_EQUALS)
                begin
                    ps_next = 1'b1;
                    pc_next = pc_inc;
                    if (pc_inc == 2'd3)
                    begin
                        err_next = ST_PAD;
                    end
                end
                else if (ps_reg)
                begin
                    err_next = ST_PAD;
                end
                else if (b64v[6])
                begin
                    err_next = ST_BAD_SYMBOL;
                end
                else
                begin
                    fsv_next = b64v[5:0];
                end
            end
        end

        if (close)
        begin
            snap_next.mode         = mode;
            // An escape left open at the close is a bad escape
            snap_next.err          = (err_next == ST_OK && esc_next != ESC_IDLE) ?
                                     ST_BAD_ESCAPE : err_next;
            snap_next.byte_count   = bc_next;
            snap_next.symbol_count = sc_next;
            snap_next.pad_count    = pc_next;
            snap_next.final_sym    = fsv_next;
            esc_next = ESC_IDLE;
            nib_next = '0;
            err_next = ST_OK;
            bc_next  = '0;
            sc_next  = '0;
            pc_next  = '0;
            ps_next  = 1'b0;
            fsv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg      <= ESC_IDLE;
            nib_reg      <= '0;
            err_reg      <= ST_OK;
            bc_reg       <= '0;
            sc_reg       <= '0;
            pc_reg       <= '0;
            ps_reg       <= 1'b0;
            fsv_reg      <= '0;
            snap_vld_reg <= 1'b0;
        end
        else
        begin
            esc_reg      <= esc_next;
            nib_reg      <= nib_next;
            err_reg      <= err_next;
            bc_reg       <= bc_next;
            sc_reg       <= sc_next;
            pc_reg       <= pc_next;
            ps_reg       <= ps_next;
            fsv_reg      <= fsv_next;
            snap_vld_reg <= close | (snap_vld_reg & ~snap_take);
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    // A recorded error holds until the payload closes
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !close) |=> (err_reg == $past(err_reg)))
        else $error("dupv_scan: sticky error changed before close");

    // Symbols are a subset of decoded bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= bc_reg)
        else $error("dupv_scan: symbol count exceeds byte count");

    // Counters restart after a close
    assert property (@(posedge clk) disable iff (!rst_n)
        close |=> (bc_reg == '0 && err_reg == ST_OK && esc_reg == ESC_IDLE))
        else $error("dupv_scan: state not cleared after close");

endmodule

`default_nettype wire

[hw/rtl/dupv_finish.sv]
// Close-of-payload evaluation and result register
`timescale 1ns / 1ps
`default_nettype none

module dupv_finish (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         snap_vld,
    input  wire dupv_pkg::snap_t              snap,
    output logic                              snap_take,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output dupv_pkg::status_t                 status,
    output logic [dupv_pkg::SIZE_W-1:0]       decoded_size
);
    import dupv_pkg::*;

    logic              out_vld_reg;
    status_t           status_reg, status_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [CNT_W-1:0]  quads;
    logic [CNT_W-1:0]  dec;
    logic [1:0]        data_len_low;
    logic              pad_bad;
    logic              noncanon;

    assign snap_take    = snap_vld & (~out_vld_reg | ~out_stall);
    assign out_valid    = out_vld_reg;
    assign status       = status_reg;
    assign decoded_size = size_reg;

    assign quads        = {2'b00, snap.symbol_count[CNT_W-1:2]};
    assign dec          = (quads << 1) + quads - {{(CNT_W-2){1'b0}}, snap.pad_count};
    assign data_len_low = snap.symbol_count[1:0] - snap.pad_count;
    assign pad_bad      = (snap.pad_count == 2'd1 && data_len_low != 2'd3) ||
                          (snap.pad_count == 2'd2 && data_len_low != 2'd2);
    assign noncanon     = (snap.pad_count == 2'd1 && (snap.final_sym & LOW2_MASK) != '0) ||
                          (snap.pad_count == 2'd2 && (snap.final_sym & LOW4_MASK) != '0);

    always_comb
    begin
        status_next = ST_OK;
        size_next   = '0;
        priority if (snap.err != ST_OK)
        begin
            status_next = snap.err;
        end
        else if (!snap.mode)
        begin
            size_next = snap.byte_count[SIZE_W-1:0];
        end
        else if (snap.symbol_count == '0)
        begin
            status_next = ST_OK;
        end
        else if (snap.symbol_count[1:0] != 2'd0)
        begin
            status_next = ST_LENGTH;
        end
        else if (pad_bad)
        begin
            status_next = ST_PAD;
        end
        else if (noncanon)
        begin
            status_next = ST_NONCANON;
        end
        else if (dec > MAX_OUT_BYTES)
        begin
            status_next = ST_LIMIT;
        end
        else
        begin
            size_next = dec[SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= snap_take | (out_vld_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            status_reg <= status_next;
            size_reg   <= size_next;
        end
    end

    // A failed payload reports no size
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && status_reg != ST_OK) |-> (size_reg == '0))
        else $error("dupv_finish: nonzero size with error status");

    // A taken snapshot always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        snap_take |=> out_vld_reg)
        else $error("dupv_finish: snapshot taken but no result");

endmodule

`default_nettype wire
